/* hdl/hff_pkg.sv */
package hff_pkg;

  localparam int VALUE_W = 64;
  localparam int FWIDTH_W = 7;
  localparam int NDIG_W = 4;
  localparam int CNT_W = 7;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_X = 8'h78;

  localparam logic [7:0] HEX_LUT [16] = '{
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
  };

  // Field segments in emission order; IDLE means no segment is active.
  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_LEAD  = 3'd1,
    PH_PFX0  = 3'd2,
    PH_PFX1  = 3'd3,
    PH_ZERO  = 3'd4,
    PH_DIGIT = 3'd5,
    PH_TRAIL = 3'd6
  } hff_phase_t;

  // One classified field, as handed from the front to the back.
  typedef struct packed {
    logic [VALUE_W-1:0]  value;
    logic [NDIG_W-1:0]   ndig_m1;
    logic [FWIDTH_W-1:0] pad;
    logic                alt;
    logic                left;
    logic                zpad;
  } hff_item_t;

  // First segment that carries characters, strictly after segment 'after'.
  function automatic hff_phase_t next_used(hff_phase_t after, hff_item_t it);
    logic has_pad;
    has_pad = (it.pad != '0);
    if (after < PH_LEAD && has_pad && !it.left && !it.zpad) return PH_LEAD;
    if (after < PH_PFX0 && it.alt) return PH_PFX0;
    if (after < PH_PFX1 && it.alt) return PH_PFX1;
    if (after < PH_ZERO && has_pad && !it.left && it.zpad) return PH_ZERO;
    if (after < PH_DIGIT) return PH_DIGIT;
    if (after < PH_TRAIL && has_pad && it.left) return PH_TRAIL;
    return PH_IDLE;
  endfunction

  // Remaining characters after the first one of a segment.
  function automatic logic [CNT_W-1:0] seg_count(hff_phase_t ph, hff_item_t it);
    case (ph)
      PH_LEAD, PH_ZERO, PH_TRAIL: return it.pad - 7'd1;
      PH_DIGIT: return {3'b000, it.ndig_m1};
      default: return '0;
    endcase
  endfunction

endpackage

/* hdl/hff_in_if.sv */
interface hff_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] value;
  logic [6:0]  field_width;
  logic        alt_prefix;
  logic        left_justify;
  logic        zero_pad;

  modport source (
    output valid, value, field_width, alt_prefix, left_justify, zero_pad,
    input ready
  );
  modport sink (
    input valid, value, field_width, alt_prefix, left_justify, zero_pad,
    output ready
  );
endinterface

/* hdl/hff_out_if.sv */
interface hff_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_out;
  logic       last_char;

  modport source (output valid, char_out, last_char, input ready);
  modport sink (input valid, char_out, last_char, output ready);
endinterface

/* hdl/hff_front.sv */
module hff_front #(
  parameter int MAX_WIDTH = 64
) (
  hff_in_if.sink            items,
  input  logic              q_ready,
  output logic              push,
  output hff_pkg::hff_item_t q_item
);

  logic [hff_pkg::NDIG_W-1:0]   ndig_m1;
  logic [4:0]                   natural_len;
  logic [hff_pkg::FWIDTH_W-1:0] width_sat;
  logic [hff_pkg::FWIDTH_W-1:0] nat_ext;

  // Highest nonzero nibble sets the digit count.
  always_comb begin
    ndig_m1 = '0;
    for (int k = 1; k < 16; k++) begin
      if (items.value[4*k +: 4] != 4'h0) ndig_m1 = 4'(k);
    end
  end

  always_comb begin
    natural_len = 5'({1'b0, ndig_m1}) + 5'd1 + (items.alt_prefix ? 5'd2 : 5'd0);
    nat_ext = {2'b00, natural_len};
    width_sat = (items.field_width > 7'(MAX_WIDTH)) ? 7'(MAX_WIDTH) : items.field_width;
  end

  always_comb begin
    q_item.value   = items.value;
    q_item.ndig_m1 = ndig_m1;
    q_item.pad     = (width_sat > nat_ext) ? width_sat - nat_ext : '0;
    q_item.alt     = items.alt_prefix;
    q_item.left    = items.left_justify;
    q_item.zpad    = items.zero_pad;
  end

  assign items.ready = q_ready;
  assign push = items.valid && q_ready;

endmodule

/* hdl/hff_queue.sv */
module hff_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  hff_pkg::hff_item_t push_item,
  output logic               not_full,
  input  logic               pop,
  output logic               not_empty,
  output hff_pkg::hff_item_t head
);

  hff_pkg::hff_item_t slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign not_full = (count != 2'd2);
  assign not_empty = (count != 2'd0);
  assign head = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

/* hdl/hff_back.sv */
module hff_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  hff_pkg::hff_item_t q_item,
  output logic               pop,
  hff_out_if.source          chars
);

  hff_pkg::hff_phase_t       ph;
  hff_pkg::hff_phase_t       ph_next;
  hff_pkg::hff_phase_t       nxt_seg;
  hff_pkg::hff_item_t        cur;
  logic [hff_pkg::CNT_W-1:0] cnt;
  logic [hff_pkg::CNT_W-1:0] cnt_next;
  logic                      advance;
  logic                      step;
  logic                      seg_end;
  logic                      is_last;
  logic                      load;
  logic [7:0]                ch;
  logic                      o_valid;
  logic [7:0]                o_char;
  logic                      o_last;

  assign advance = !o_valid || chars.ready;
  assign step = advance && (ph != hff_pkg::PH_IDLE);

  // Next state: walk the segments, then pull the next field.
  always_comb begin
    seg_end = (ph == hff_pkg::PH_PFX0) || (ph == hff_pkg::PH_PFX1) || (cnt == '0);
    nxt_seg = hff_pkg::next_used(ph, cur);
    is_last = step && seg_end && (nxt_seg == hff_pkg::PH_IDLE);
    load = q_valid && ((ph == hff_pkg::PH_IDLE) || is_last);
    ph_next = ph;
    cnt_next = cnt;
    if (load) begin
      ph_next = hff_pkg::next_used(hff_pkg::PH_IDLE, q_item);
      cnt_next = hff_pkg::seg_count(ph_next, q_item);
    end else if (step && seg_end) begin
      ph_next = nxt_seg;
      cnt_next = hff_pkg::seg_count(nxt_seg, cur);
    end else if (step) begin
      cnt_next = cnt - 7'd1;
    end
  end

  // Outputs: character of the current segment.
  always_comb begin
    case (ph)
      hff_pkg::PH_PFX0, hff_pkg::PH_ZERO: ch = hff_pkg::CH_ZERO;
      hff_pkg::PH_PFX1: ch = hff_pkg::CH_X;
      hff_pkg::PH_DIGIT: ch = hff_pkg::HEX_LUT[cur.value[{cnt[3:0], 2'b00} +: 4]];
      default: ch = hff_pkg::CH_SPACE;
    endcase
  end

  assign pop = load;

  always_ff @(posedge clk) begin
    if (rst) begin
      ph <= hff_pkg::PH_IDLE;
      o_valid <= 1'b0;
    end else begin
      ph <= ph_next;
      if (step) o_valid <= 1'b1;
      else if (chars.ready) o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    cnt <= cnt_next;
    if (load) cur <= q_item;
    if (step) begin
      o_char <= ch;
      o_last <= is_last;
    end
  end

  assign chars.valid = o_valid;
  assign chars.char_out = o_char;
  assign chars.last_char = o_last;

  a_digit_index: assert property (@(posedge clk) disable iff (rst)
    (ph == hff_pkg::PH_DIGIT) |-> (cnt[6:4] == 3'b000))
    else $error("digit index beyond the value");

  a_prefix_pair: assert property (@(posedge clk) disable iff (rst)
    (step && ph == hff_pkg::PH_PFX0) |=> (ph == hff_pkg::PH_PFX1))
    else $error("prefix broken after its first character");

  a_trail_entry: assert property (@(posedge clk) disable iff (rst)
    (ph == hff_pkg::PH_TRAIL && $past(ph) != hff_pkg::PH_TRAIL)
      |-> ($past(ph) == hff_pkg::PH_DIGIT))
    else $error("trailing spaces not preceded by digits");

  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    (load && !is_last) |-> (ph == hff_pkg::PH_IDLE))
    else $error("field pulled while another is in progress");

endmodule

/* hdl/hex_field_formatter_core.sv */
// An item passes through the queue and the back's segment state to the output register.
// One character per cycle while chars.ready is high; a field has at most 18 characters
//   without padding and at most MAX_WIDTH with it; fields follow with no gap between them.
// The front takes a new item as long as fewer than two classified fields wait in the queue.
// Reset (rst, synchronous, active high) empties the queue and the output register;
//   no field is kept across it.
module hex_field_formatter_core #(
  parameter int MAX_WIDTH = 64
) (
  input  logic       clk,
  input  logic       rst,
  hff_in_if.sink     items,
  hff_out_if.source  chars
);

  // Front: saturate the width, count digits, size the padding.
  hff_pkg::hff_item_t cls_item;
  hff_pkg::hff_item_t head;
  logic               push;
  logic               q_ready;
  logic               q_valid;
  logic               pop;

  hff_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .items  (items),
    .q_ready(q_ready),
    .push   (push),
    .q_item (cls_item)
  );

  // Queue: hold classified fields so that the front keeps taking transfers
  // while the back streams characters.
  hff_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_item(cls_item),
    .not_full (q_ready),
    .pop      (pop),
    .not_empty(q_valid),
    .head     (head)
  );

  // Back: advance through spaces, prefix, zeros, digits and trailing spaces,
  // one character per output transfer; drop into the next field on the last one.
  hff_back u_back (
    .clk    (clk),
    .rst    (rst),
    .q_valid(q_valid),
    .q_item (head),
    .pop    (pop),
    .chars  (chars)
  );

endmodule
